>>> src/url_percent_decoder_top_macros.svh
// Assertion macros shared by the percent decoder RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef URL_PERCENT_DECODER_TOP_MACROS_SVH
`define URL_PERCENT_DECODER_TOP_MACROS_SVH

// same-cycle implication
`define UPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/upd_pkg.sv
// Types, constants and hex decode helper for the percent decoder.
// No dependencies.
`default_nettype none

package upd_pkg;

  localparam logic [7:0] PCT_CHAR = 8'h25;
  localparam int         NIBBLE_W = 4;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  // one queue entry: up to three output bytes from one input beat
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       last;
  } upd_entry_t;

  // returns {valid, nibble}
  function automatic logic [NIBBLE_W:0] hex_decode(input logic [7:0] c);
    logic [7:0] t;
    logic [NIBBLE_W:0] r;
    r = '0;
    t = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30;
      r = {1'b1, t[NIBBLE_W-1:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      t = c - 8'h37;
      r = {1'b1, t[NIBBLE_W-1:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      t = c - 8'h57;
      r = {1'b1, t[NIBBLE_W-1:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/upd_front.sv
// Front end: accepts input beats, tracks the escape phase and builds queue entries.
// Depends on upd_pkg and the assertion macro header.
`default_nettype none
`include "url_percent_decoder_top_macros.svh"

module upd_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [7:0]         in_byte,
  input  wire logic               in_last,
  input  wire logic               q_full,
  output logic                    in_ready,
  output logic                    push,
  output upd_pkg::upd_entry_t     push_entry
);
  import upd_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [7:0]          held_r, held_nxt;
  logic                accept;
  logic [NIBBLE_W:0]   hx_in;
  logic [NIBBLE_W:0]   hx_held;
  logic                pct_open;
  upd_entry_t          entry;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign hx_in    = hex_decode(in_byte);
  assign hx_held  = hex_decode(held_r);
  assign pct_open = (in_byte == PCT_CHAR) && !in_last;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    if (accept) begin
      unique case (phase_r)
        PH_PCT: begin
          if (hx_in[NIBBLE_W] && !in_last) begin
            phase_nxt = PH_DIGIT;
            held_nxt  = in_byte;
          end else begin
            phase_nxt = pct_open ? PH_PCT : PH_IDLE;
          end
        end
        PH_DIGIT: begin
          if (hx_in[NIBBLE_W]) begin
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = pct_open ? PH_PCT : PH_IDLE;
          end
        end
        default: begin
          phase_nxt = pct_open ? PH_PCT : PH_IDLE;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    entry      = '0;
    entry.last = in_last;
    unique case (phase_r)
      PH_PCT: begin
        if (!(hx_in[NIBBLE_W] && !in_last)) begin
          entry.b0    = PCT_CHAR;
          entry.b1    = in_byte;
          entry.count = pct_open ? 2'd1 : 2'd2;
        end
      end
      PH_DIGIT: begin
        if (hx_in[NIBBLE_W]) begin
          entry.b0    = {hx_held[NIBBLE_W-1:0], hx_in[NIBBLE_W-1:0]};
          entry.count = 2'd1;
        end else begin
          entry.b0    = PCT_CHAR;
          entry.b1    = held_r;
          entry.b2    = in_byte;
          entry.count = pct_open ? 2'd2 : 2'd3;
        end
      end
      default: begin
        if (!pct_open) begin
          entry.b0    = in_byte;
          entry.count = 2'd1;
        end
      end
    endcase
  end

  assign push       = accept && (entry.count != 2'd0);
  assign push_entry = entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

  `UPD_ASSERT_NEXT(a_last_closes, accept && in_last, phase_r == PH_IDLE, "escape open after last")
  `UPD_ASSERT_NOW(a_held_hex, phase_r == PH_DIGIT, hx_held[NIBBLE_W], "held digit not hex")
  `UPD_ASSERT_NOW(a_last_pushes, accept && in_last, push, "last beat produced no entry")

endmodule

`default_nettype wire

>>> src/upd_queue.sv
// Short entry queue between front and back ends.
// Depends on upd_pkg.
`default_nettype none

module upd_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire upd_pkg::upd_entry_t push_entry,
  input  wire logic                pop,
  output upd_pkg::upd_entry_t      head,
  output logic                     empty,
  output logic                     full
);
  import upd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  upd_entry_t        slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/upd_back.sv
// Back end: serializes queue entries into single output bytes through an output register.
// Depends on upd_pkg and the assertion macro header.
`default_nettype none
`include "url_percent_decoder_top_macros.svh"

module upd_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire upd_pkg::upd_entry_t head,
  input  wire logic                empty,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_byte,
  output logic                     out_last
);
  import upd_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       load;
  logic       final_byte;
  logic [7:0] sel_byte;

  assign load       = !empty && (!valid_r || out_ready);
  assign final_byte = (idx_r == (head.count - 2'd1));
  assign pop        = load && final_byte;

  always_comb begin
    unique case (idx_r)
      2'd0:    sel_byte = head.b0;
      2'd1:    sel_byte = head.b1;
      default: sel_byte = head.b2;
    endcase
  end

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = final_byte ? 2'd0 : idx_r + 2'd1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= sel_byte;
      last_r <= head.last && final_byte;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

  `UPD_ASSERT_NOW(a_idx_in_range, !empty, idx_r < head.count, "byte index past entry")
  `UPD_ASSERT_NOW(a_idle_idx, empty, idx_r == 2'd0, "byte index left over")
  `UPD_ASSERT_NEXT(a_load_shows, load, valid_r, "loaded byte not shown")

endmodule

`default_nettype wire

>>> src/url_percent_decoder_top.sv
// Top level of the streaming URL percent decoder.
// Depends on upd_pkg, upd_front, upd_queue and upd_back.
//
//   channel | dir | handshake            | payload
//   in_     | in  | in_tvalid/in_tready  | in_tdata = in_byte, in_tlast = in_last
//   out_    | out | out_tvalid/out_tready| out_tdata = out_byte, out_tlast = out_last
//
// One input beat per cycle while each beat yields at most one byte and the output is
// not held off; a beat that yields two or three bytes holds the back end's output register for each of its bytes.
// First output byte passes through a queue slot and then the back end's output register before it is offered.
// Reset is synchronous, active low; no clearing pass.
// The front end stalls only when the QUEUE_DEPTH-entry queue is full.
`default_nettype none

module url_percent_decoder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,    // [7:0] in_byte
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,   // [7:0] out_byte
  output logic            out_tlast
);
  import upd_pkg::*;

  logic       push;
  upd_entry_t push_entry;
  upd_entry_t head;
  logic       q_empty;
  logic       q_full;
  logic       pop;

  upd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .q_full     (q_full),
    .in_ready   (in_tready),
    .push       (push),
    .push_entry (push_entry)
  );

  upd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  upd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire

>>> tb/url_percent_decoder_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for url_percent_decoder_top: escape decoding, broken escapes,
// end-of-string flushes and backpressure. Needs upd_pkg and the decoder RTL only.
module url_percent_decoder_top_tb;
  import upd_pkg::*;

  localparam int ITEM_TARGET = 170;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } decoded_beat_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;    // [7:0] in_byte
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;   // [7:0] out_byte
  logic       out_tlast;

  decoded_beat_t decoded_q[$];
  logic [7:0]    step_bytes[$];
  phase_t        esc_phase;
  logic [7:0]    held_char;

  int  fails = 0;
  int  sent_cnt = 0;
  int  idle_cycles = 0;
  bit  no_idle = 1'b0;
  int  hold_req = 0;
  int  hold_left = 0;
  int  stall_left = 0;
  int  ready_roll;

  url_percent_decoder_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #10 clk = ~clk;

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    return -1;
  endfunction

  function automatic void plain_char(input logic [7:0] b, input logic l);
    if (b == PCT_CHAR && !l) begin
      esc_phase = PH_PCT;
    end else begin
      step_bytes.push_back(b);
      esc_phase = PH_IDLE;
    end
  endfunction

  // expected decoded bytes for one accepted input beat
  function automatic void decode_beat(input logic [7:0] b, input logic l);
    int            lo;
    decoded_beat_t beat;
    step_bytes.delete();
    lo = hex_nibble(b);
    case (esc_phase)
      PH_PCT: begin
        if (lo >= 0 && !l) begin
          held_char = b;
          esc_phase = PH_DIGIT;
        end else begin
          step_bytes.push_back(PCT_CHAR);
          plain_char(b, l);
        end
      end
      PH_DIGIT: begin
        if (lo >= 0) begin
          step_bytes.push_back(8'(hex_nibble(held_char) * 16 + lo));
          esc_phase = PH_IDLE;
        end else begin
          step_bytes.push_back(PCT_CHAR);
          step_bytes.push_back(held_char);
          plain_char(b, l);
        end
      end
      default: plain_char(b, l);
    endcase
    if (l) esc_phase = PH_IDLE;
    foreach (step_bytes[i]) begin
      beat.data = step_bytes[i];
      beat.last = l && (i == step_bytes.size() - 1);
      decoded_q.push_back(beat);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_char(input logic [7:0] b, input logic l);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    decode_beat(b, l);
    sent_cnt++;
  endtask

  task automatic send_text(input string s, input bit end_last);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], end_last && (i == s.len() - 1));
  endtask

  task automatic send_run(input logic [7:0] run[$], input bit end_last);
    foreach (run[i]) send_char(run[i], end_last && (i == run.size() - 1));
  endtask

  function automatic logic [7:0] rand_hex_char();
    int nib;
    nib = $urandom_range(0, 15);
    if (nib < 10) return 8'("0" + nib);
    return $urandom_range(0, 1) ? 8'("A" + nib - 10) : 8'("a" + nib - 10);
  endfunction

  // well-formed escapes mixed with noise, plus stray percents and near-hex bytes unless clean
  function automatic void build_string(output logic [7:0] run[$], input bit clean);
    int len;
    int r;
    logic [7:0] edges[6] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};
    run.delete();
    len = $urandom_range(1, 10);
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        run.push_back(PCT_CHAR);
        run.push_back(rand_hex_char());
        run.push_back(rand_hex_char());
      end else if (r < 55 && !clean) begin
        run.push_back(PCT_CHAR);
        if ($urandom_range(0, 1)) run.push_back(rand_hex_char());
      end else if (r < 65 && !clean) begin
        run.push_back(edges[$urandom_range(0, 5)]);
      end else begin
        run.push_back(8'($urandom_range(0, 255)));
        if (clean && run[run.size() - 1] == PCT_CHAR) run[run.size() - 1] = "z";
      end
    end
  endfunction

  task automatic test_directed();
    send_text("%41", 1'b1);
    send_text("%aF", 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_text("%%41", 1'b0);
    send_text("%4Z", 1'b0);
    send_text("%4%f0", 1'b1);
    send_text("%", 1'b1);
    send_text("%9", 1'b1);
  endtask

  task automatic test_backpressure();
    logic [7:0] run[$];
    no_idle  = 1'b1;
    hold_req = 150;
    build_string(run, 1'b1);
    while (run.size() < 12) run.push_back(8'($urandom_range(0, 255)));
    send_run(run, 1'b1);
    no_idle = 1'b0;
  endtask

  task automatic test_streaming();
    logic [7:0] run[$];
    no_idle = 1'b1;
    repeat (3) begin
      build_string(run, 1'b1);
      send_run(run, 1'b1);
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_strings();
    logic [7:0] run[$];
    while (sent_cnt < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 80) begin
        build_string(run, 1'b0);
        send_run(run, 1'b1);
      end else begin
        repeat ($urandom_range(1, 4))
          send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (no_idle) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 70) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        stall_left = (ready_roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
      end
    end
  end

  always @(posedge clk) begin
    decoded_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        $error("out_byte: no beat expected, got %02h", out_tdata);
        fails++;
      end else begin
        want = decoded_q.pop_front();
        if (out_tdata !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, out_tdata);
          fails++;
        end
        if (out_tlast !== want.last) begin
          $error("out_last: expected %0b, got %0b", want.last, out_tlast);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    esc_phase = PH_IDLE;
    held_char = 8'h00;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_backpressure();
    test_streaming();
    test_random_strings();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/upd_pkg.sv
src/upd_front.sv
src/upd_queue.sv
src/upd_back.sv
src/url_percent_decoder_top.sv
tb/url_percent_decoder_top_tb.sv
